>>> design/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared widths, reset values, codes and helpers of the angle/bias Kalman
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package abkf_pkg;

   localparam int SIG_FRAC  = 24;
   localparam int COV_FRAC  = 44;
   localparam int SIG_W     = 32;
   localparam int COV_W     = 48;
   localparam int REG_W     = 45;
   localparam int DT_W      = 25;
   localparam int OPND_W    = COV_W + 1;
   localparam int MRES_W    = 64;
   localparam int WIDE_W    = 65;
   localparam int CSR_IDX_W = 2;

   localparam logic [REG_W-1:0] RST_QA  = 45'd52776558133;
   localparam logic [REG_W-1:0] RST_QB  = 45'd1759218604442;
   localparam logic [REG_W-1:0] RST_R   = 45'd8796093022;
   localparam logic signed [COV_W-1:0] RST_P00 = 48'sd1759218604;
   localparam logic signed [COV_W-1:0] RST_P11 = 48'sd175921860444;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [OPND_W-1:0] opnd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE,
      ST_MUL_ISSUE,
      ST_MUL_WAIT,
      ST_DIV_ISSUE,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_PRED,
      OP_T,
      OP_P00,
      OP_P11,
      OP_K0,
      OP_K1,
      OP_ANG,
      OP_BIAS,
      OP_C00,
      OP_C01,
      OP_C10,
      OP_C11
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_NOISE,
      CSR_BIAS_NOISE,
      CSR_MEAS_NOISE
   } csr_idx_type;

   typedef struct packed {
      logic     start;
      opnd_type a;
      opnd_type b;
      logic     cov_shift;
      logic     w48;
   } mul_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef struct packed {
      logic                    start;
      logic signed [COV_W-1:0] n;
      logic [COV_W:0]          d;
   } div_req_type;

   function automatic wide_type sx32(input logic signed [SIG_W-1:0] x);
      return {{(WIDE_W-SIG_W){x[SIG_W-1]}}, x};
   endfunction

   function automatic wide_type sx48(input logic signed [COV_W-1:0] x);
      return {{(WIDE_W-COV_W){x[COV_W-1]}}, x};
   endfunction

   function automatic wide_type sx64(input logic signed [MRES_W-1:0] x);
      return {{(WIDE_W-MRES_W){x[MRES_W-1]}}, x};
   endfunction

   function automatic wide_type zx45(input logic [REG_W-1:0] x);
      return {{(WIDE_W-REG_W){1'b0}}, x};
   endfunction

   function automatic logic signed [SIG_W-1:0] sat32(input wide_type x);
      if (x[WIDE_W-1:SIG_W-1] == '0 || x[WIDE_W-1:SIG_W-1] == '1) begin
         return x[SIG_W-1:0];
      end else if (x[WIDE_W-1]) begin
         return {1'b1, {(SIG_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SIG_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [COV_W-1:0] sat48(input wide_type x);
      if (x[WIDE_W-1:COV_W-1] == '0 || x[WIDE_W-1:COV_W-1] == '1) begin
         return x[COV_W-1:0];
      end else if (x[WIDE_W-1]) begin
         return {1'b1, {(COV_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COV_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

>>> design/abkf_req_if.sv
// ----------------------------------------------------------------------------
// abkf_req_if
// Request channel: restart or update item.
// ----------------------------------------------------------------------------
`default_nettype none

interface abkf_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic signed [abkf_pkg::SIG_W-1:0]  angle_measurement;
   logic signed [abkf_pkg::SIG_W-1:0]  rate_measurement;
   logic [abkf_pkg::DT_W-1:0]          time_step;

   modport source (output valid, kind, angle_measurement, rate_measurement, time_step,
                   input ready);
   modport sink   (input valid, kind, angle_measurement, rate_measurement, time_step,
                   output ready);
endinterface

`default_nettype wire

>>> design/abkf_rsp_if.sv
// ----------------------------------------------------------------------------
// abkf_rsp_if
// Response channel: filtered angle, bias and corrected rate.
// ----------------------------------------------------------------------------
`default_nettype none

interface abkf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [abkf_pkg::SIG_W-1:0]  angle_estimate;
   logic signed [abkf_pkg::SIG_W-1:0]  bias_estimate;
   logic signed [abkf_pkg::SIG_W-1:0]  corrected_rate;

   modport source (output valid, angle_estimate, bias_estimate, corrected_rate,
                   input ready);
   modport sink   (input valid, angle_estimate, bias_estimate, corrected_rate,
                   output ready);
endinterface

`default_nettype wire

>>> design/abkf_csr_if.sv
// ----------------------------------------------------------------------------
// abkf_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface abkf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [abkf_pkg::CSR_IDX_W-1:0]    index;
   logic [abkf_pkg::REG_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/abkf_mul.sv
// ----------------------------------------------------------------------------
// abkf_mul
// Shared sign-magnitude multiplier: four 24x24 partial products, then
// round half away from zero, shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module abkf_mul (
   input  wire                               clock,
   input  wire                               reset,
   input  abkf_pkg::mul_req_type             req,
   output abkf_pkg::unit_stat_type           stat,
   output logic signed [abkf_pkg::MRES_W-1:0] result
);
   import abkf_pkg::*;

   localparam int MAG_W  = COV_W;
   localparam int HALF_W = MAG_W / 2;
   localparam int PROD_W = 2 * MAG_W;
   localparam int RND_W  = PROD_W + 1;
   localparam int SAT_W  = MRES_W - 1;
   localparam logic [2:0] LAST = 3'd4;
   localparam logic [RND_W-1:0] RND_SIG = RND_W'(1) << (SIG_FRAC - 1);
   localparam logic [RND_W-1:0] RND_COV = RND_W'(1) << (COV_FRAC - 1);

   logic               busy_ff, busy_in, done_ff, done_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [MAG_W-1:0]   ma_ff, ma_in, mb_ff, mb_in;
   logic               neg_ff, neg_in, cov_ff, cov_in, w48_ff, w48_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic signed [MRES_W-1:0] res_ff, res_in;

   opnd_type           a_abs, b_abs;
   logic [HALF_W-1:0]  a_half, b_half;
   logic [MAG_W-1:0]   pp;
   logic [PROD_W-1:0]  pp_w;
   logic [1:0]         lane;
   logic [RND_W-1:0]   rnd, shifted;
   logic [SAT_W-1:0]   lim, lim_s, mag_v;

   always_comb begin
      a_abs  = req.a[OPND_W-1] ? -req.a : req.a;
      b_abs  = req.b[OPND_W-1] ? -req.b : req.b;
      a_half = cnt_ff[1] ? ma_ff[MAG_W-1:HALF_W] : ma_ff[HALF_W-1:0];
      b_half = cnt_ff[0] ? mb_ff[MAG_W-1:HALF_W] : mb_ff[HALF_W-1:0];
      pp     = a_half * b_half;
      lane   = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
      case (lane)
         2'd0:    pp_w = {{MAG_W{1'b0}}, pp};
         2'd1:    pp_w = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
         default: pp_w = {pp, {MAG_W{1'b0}}};
      endcase

      rnd     = {1'b0, acc_ff} + (cov_ff ? RND_COV : RND_SIG);
      shifted = cov_ff ? (rnd >> COV_FRAC) : (rnd >> SIG_FRAC);
      lim     = w48_ff ? (SAT_W'(1) << (COV_W - 1)) : (SAT_W'(1) << (SAT_W - 1));
      lim_s   = neg_ff ? lim : lim - SAT_W'(1);
      mag_v   = (shifted > {{(RND_W-SAT_W){1'b0}}, lim_s}) ? lim_s : shifted[SAT_W-1:0];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      cov_in  = cov_ff;
      w48_in  = w48_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ma_in   = a_abs[MAG_W-1:0];
         mb_in   = b_abs[MAG_W-1:0];
         neg_in  = req.a[OPND_W-1] ^ req.b[OPND_W-1];
         cov_in  = req.cov_shift;
         w48_in  = req.w48;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -{1'b0, mag_v} : {1'b0, mag_v};
         end else begin
            acc_in = acc_ff + pp_w;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      cov_ff <= cov_in;
      w48_ff <= w48_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

`default_nettype wire

>>> design/abkf_div.sv
// ----------------------------------------------------------------------------
// abkf_div
// Restoring divider for the gains: (n << COV_FRAC) / d, two quotient bits
// per cycle, truncated toward zero, saturated to 48 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module abkf_div (
   input  wire                               clock,
   input  wire                               reset,
   input  abkf_pkg::div_req_type             req,
   output abkf_pkg::unit_stat_type           stat,
   output logic signed [abkf_pkg::COV_W-1:0] result
);
   import abkf_pkg::*;

   localparam int NUM_W   = COV_W + COV_FRAC;
   localparam int STEPS   = 2;
   localparam int ITERS   = NUM_W / STEPS;
   localparam int CNT_W   = $clog2(ITERS + 1);
   localparam int REM_W   = COV_W + 2;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(ITERS);

   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]        num_ff, num_in, quo_ff, quo_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [COV_W:0]          d_ff, d_in;
   logic                    neg_ff, neg_in;
   logic signed [COV_W-1:0] res_ff, res_in;

   logic signed [COV_W-1:0] n_abs;
   logic [REM_W-1:0]        r;
   logic [NUM_W-1:0]        nm, q, lim, lim_s, mq;

   always_comb begin
      n_abs = req.n[COV_W-1] ? -req.n : req.n;
      r  = rem_ff;
      nm = num_ff;
      q  = quo_ff;
      for (int i = 0; i < STEPS; i++) begin
         r  = {r[REM_W-2:0], nm[NUM_W-1]};
         nm = nm << 1;
         q  = q << 1;
         if (r >= {1'b0, d_ff}) begin
            r    = r - {1'b0, d_ff};
            q[0] = 1'b1;
         end
      end
      lim   = NUM_W'(1) << (COV_W - 1);
      lim_s = neg_ff ? lim : lim - NUM_W'(1);
      mq    = (quo_ff > lim_s) ? lim_s : quo_ff;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = {n_abs, {COV_FRAC{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         d_in    = req.d;
         neg_in  = req.n[COV_W-1];
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -mq[COV_W-1:0] : mq[COV_W-1:0];
         end else begin
            rem_in = r;
            num_in = nm;
            quo_in = q;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

`default_nettype wire

>>> design/angle_bias_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_top
// Two-state Kalman filter for angle and gyro bias, sequenced over one
// shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   kind, angle_measurement, rate_measurement, time_step
//  rsp      out  angle_estimate, bias_estimate, corrected_rate
//  csr      in   index, data (always ready)
//
//  Update request: ten passes through the multiplier and two passes
//  through the divider. A restart request uses neither unit. Synchronous
//  reset restores the registers and the filter state. The response
//  register holds while rsp is stalled; a finished request waits until
//  the previous response has left the register.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_bias_kalman_filter_top (
   input  wire         clock,
   input  wire         reset,
   abkf_req_if.sink    req_chan,
   abkf_rsp_if.source  rsp_chan,
   abkf_csr_if.sink    csr_chan
);
   import abkf_pkg::*;

   typedef struct packed {
      logic signed [SIG_W-1:0] angle;
      logic signed [SIG_W-1:0] bias;
      logic signed [COV_W-1:0] p00;
      logic signed [COV_W-1:0] p01;
      logic signed [COV_W-1:0] p10;
      logic signed [COV_W-1:0] p11;
   } filt_type;

   typedef struct packed {
      logic signed [SIG_W-1:0] rate;
      logic signed [SIG_W-1:0] pred;
      logic signed [COV_W-1:0] inner;
      logic signed [COV_W-1:0] np00;
      logic signed [COV_W-1:0] np01;
      logic signed [COV_W-1:0] np10;
      logic signed [COV_W-1:0] np11;
      logic [COV_W:0]          s;
      logic signed [COV_W-1:0] k0;
      logic signed [COV_W-1:0] k1;
   } work_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   filt_type  filt_ff, filt_in;
   work_type  work_ff, work_in;

   logic [REG_W-1:0] qa_ff, qa_in, qb_ff, qb_in, r_ff, r_in;
   logic signed [SIG_W-1:0] meas_ff, meas_in, rm_ff, rm_in;
   logic [DT_W-1:0]  dt_ff, dt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SIG_W-1:0] out_angle_ff, out_angle_in;
   logic signed [SIG_W-1:0] out_bias_ff, out_bias_in;
   logic signed [SIG_W-1:0] out_rate_ff, out_rate_in;

   mul_req_type   mul_req;
   unit_stat_type mul_stat, div_stat;
   div_req_type   div_req;
   logic signed [MRES_W-1:0] mul_res;
   logic signed [COV_W-1:0]  div_res;

   logic                    mul_start, div_start, load;
   logic signed [SIG_W:0]   innov;
   opnd_type                dt_op, innov_op;
   logic signed [COV_W-1:0] np00_v;
   wide_type                s_sum;

   abkf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .stat   (mul_stat),
      .result (mul_res)
   );

   abkf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .stat   (div_stat),
      .result (div_res)
   );

   // register writes
   always_comb begin
      qa_in = qa_ff;
      qb_in = qb_ff;
      r_in  = r_ff;
      if (csr_chan.valid) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_ANGLE_NOISE: qa_in = csr_chan.data;
            CSR_BIAS_NOISE:  qb_in = csr_chan.data;
            CSR_MEAS_NOISE:  r_in  = csr_chan.data;
            default: ;
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      innov    = {meas_ff[SIG_W-1], meas_ff} - {work_ff.pred[SIG_W-1], work_ff.pred};
      dt_op    = {{(OPND_W-DT_W){1'b0}}, dt_ff};
      innov_op = {{(OPND_W-SIG_W-1){innov[SIG_W]}}, innov};
      mul_req.start     = mul_start;
      mul_req.a         = dt_op;
      mul_req.b         = dt_op;
      mul_req.cov_shift = 1'b0;
      mul_req.w48       = 1'b1;
      case (op_ff)
         OP_PRED: begin
            mul_req.b   = {{(OPND_W-SIG_W){work_ff.rate[SIG_W-1]}}, work_ff.rate};
            mul_req.w48 = 1'b0;
         end
         OP_T:    mul_req.b = {filt_ff.p11[COV_W-1], filt_ff.p11};
         OP_P00:  mul_req.b = {work_ff.inner[COV_W-1], work_ff.inner};
         OP_P11:  mul_req.a = {{(OPND_W-REG_W){1'b0}}, qb_ff};
         default: begin
            mul_req.cov_shift = 1'b1;
            mul_req.w48       = 1'b0;
            if (op_ff == OP_ANG || op_ff == OP_C00 || op_ff == OP_C01) begin
               mul_req.a = {work_ff.k0[COV_W-1], work_ff.k0};
            end else begin
               mul_req.a = {work_ff.k1[COV_W-1], work_ff.k1};
            end
            if (op_ff == OP_ANG || op_ff == OP_BIAS) begin
               mul_req.b = innov_op;
            end else if (op_ff == OP_C00 || op_ff == OP_C10) begin
               mul_req.b = {work_ff.np00[COV_W-1], work_ff.np00};
            end else begin
               mul_req.b = {work_ff.np01[COV_W-1], work_ff.np01};
            end
         end
      endcase
      div_req.start = div_start;
      div_req.n     = (op_ff == OP_K0) ? work_ff.np00 : work_ff.np10;
      div_req.d     = work_ff.s;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      filt_in   = filt_ff;
      work_in   = work_ff;
      meas_in   = meas_ff;
      rm_in     = rm_ff;
      dt_in     = dt_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      load      = 1'b0;
      np00_v    = sat48(sx48(filt_ff.p00) + sx64(mul_res));
      s_sum     = sx48(np00_v) + zx45(r_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               meas_in = req_chan.angle_measurement;
               rm_in   = req_chan.rate_measurement;
               dt_in   = req_chan.time_step;
               if (!req_chan.kind) begin
                  filt_in.angle = req_chan.angle_measurement;
                  filt_in.bias  = '0;
                  filt_in.p00   = RST_P00;
                  filt_in.p01   = '0;
                  filt_in.p10   = '0;
                  filt_in.p11   = RST_P11;
                  work_in.rate  = '0;
                  state_in      = ST_FINISH;
               end else begin
                  state_in = ST_RATE;
               end
            end
         end
         ST_RATE: begin
            work_in.rate = sat32(sx32(rm_ff) - sx32(filt_ff.bias));
            op_in        = OP_PRED;
            state_in     = ST_MUL_ISSUE;
         end
         ST_MUL_ISSUE: begin
            mul_start = 1'b1;
            state_in  = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mul_stat.done) begin
               state_in = ST_MUL_ISSUE;
               case (op_ff)
                  OP_PRED: begin
                     work_in.pred = sat32(sx32(filt_ff.angle) + sx64(mul_res));
                     op_in        = OP_T;
                  end
                  OP_T: begin
                     work_in.inner = sat48(sx64(mul_res) - sx48(filt_ff.p01)
                                           - sx48(filt_ff.p10) + zx45(qa_ff));
                     work_in.np01  = sat48(sx48(filt_ff.p01) - sx64(mul_res));
                     work_in.np10  = sat48(sx48(filt_ff.p10) - sx64(mul_res));
                     op_in         = OP_P00;
                  end
                  OP_P00: begin
                     work_in.np00 = np00_v;
                     work_in.s    = (s_sum < 65'sd1) ? (COV_W+1)'(1) : s_sum[COV_W:0];
                     op_in        = OP_P11;
                  end
                  OP_P11: begin
                     work_in.np11 = sat48(sx48(filt_ff.p11) + sx64(mul_res));
                     op_in        = OP_K0;
                     state_in     = ST_DIV_ISSUE;
                  end
                  OP_ANG: begin
                     filt_in.angle = sat32(sx32(work_ff.pred) + sx64(mul_res));
                     op_in         = OP_BIAS;
                  end
                  OP_BIAS: begin
                     filt_in.bias = sat32(sx32(filt_ff.bias) + sx64(mul_res));
                     op_in        = OP_C00;
                  end
                  OP_C00: begin
                     filt_in.p00 = sat48(sx48(work_ff.np00) - sx64(mul_res));
                     op_in       = OP_C01;
                  end
                  OP_C01: begin
                     filt_in.p01 = sat48(sx48(work_ff.np01) - sx64(mul_res));
                     op_in       = OP_C10;
                  end
                  OP_C10: begin
                     filt_in.p10 = sat48(sx48(work_ff.np10) - sx64(mul_res));
                     op_in       = OP_C11;
                  end
                  default: begin
                     filt_in.p11 = sat48(sx48(work_ff.np11) - sx64(mul_res));
                     state_in    = ST_FINISH;
                  end
               endcase
            end
         end
         ST_DIV_ISSUE: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (op_ff == OP_K0) begin
                  work_in.k0 = div_res;
                  op_in      = OP_K1;
                  state_in   = ST_DIV_ISSUE;
               end else begin
                  work_in.k1 = div_res;
                  op_in      = OP_ANG;
                  state_in   = ST_MUL_ISSUE;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || load;
      out_angle_in = load ? filt_ff.angle : out_angle_ff;
      out_bias_in  = load ? filt_ff.bias  : out_bias_ff;
      out_rate_in  = load ? work_ff.rate  : out_rate_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_PRED;
         rsp_valid_ff <= 1'b0;
         qa_ff        <= RST_QA;
         qb_ff        <= RST_QB;
         r_ff         <= RST_R;
         filt_ff      <= '{angle: '0, bias: '0, p00: RST_P00, p01: '0, p10: '0,
                           p11: RST_P11};
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         qa_ff        <= qa_in;
         qb_ff        <= qb_in;
         r_ff         <= r_in;
         filt_ff      <= filt_in;
      end
      work_ff      <= work_in;
      meas_ff      <= meas_in;
      rm_ff        <= rm_in;
      dt_ff        <= dt_in;
      out_angle_ff <= out_angle_in;
      out_bias_ff  <= out_bias_in;
      out_rate_ff  <= out_rate_in;
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.angle_estimate = out_angle_ff;
   assign rsp_chan.bias_estimate  = out_bias_ff;
   assign rsp_chan.corrected_rate = out_rate_ff;

`ifndef SYNTHESIS
   a_mul_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_stat.busy |-> state_ff == ST_MUL_WAIT)
      else $error("multiplier busy outside its wait state");

   a_div_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DIV_WAIT)
      else $error("divider busy outside its wait state");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider active together");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> state_ff != ST_IDLE)
      else $error("request accepted without leaving idle");
`endif

endmodule

`default_nettype wire

>>> bench/abkf_estimate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_estimate_checker
// Watches the request, response and register channels of the angle/bias
// Kalman filter. It keeps its own fixed-point copy of the filter state and
// noise settings, predicts the estimates for every accepted request and
// compares each response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module abkf_estimate_checker (
   input  wire   clock,
   input  wire   reset,
   abkf_req_if   req_chan,
   abkf_rsp_if   rsp_chan,
   abkf_csr_if   csr_chan,
   output int    fail_count,
   output int    pending,
   output int    checked
);
   import abkf_pkg::*;

   typedef logic signed [127:0] big_type;

   typedef struct {
      logic signed [SIG_W-1:0] angle;
      logic signed [SIG_W-1:0] bias;
      logic signed [SIG_W-1:0] rate;
   } estimate_type;

   estimate_type            estimate_q[$];
   logic signed [SIG_W-1:0] angle_st, bias_st;
   logic signed [COV_W-1:0] p_aa, p_ab, p_ba, p_bb;
   logic [REG_W-1:0]        q_angle, q_bias, r_meas;
   int                      mismatches;

   function automatic big_type clamp(input big_type x, input int w);
      big_type lim;
      lim = big_type'(1) <<< (w - 1);
      if (x > lim - 1) return lim - 1;
      if (x < -lim) return -lim;
      return x;
   endfunction

   // exact product, shifted with rounding half away from zero, then clamped
   function automatic big_type scaled_product(input big_type a, input big_type b,
                                              input int sh, input int w);
      big_type p, m;
      logic    neg;
      p   = a * b;
      neg = p < 0;
      m   = neg ? -p : p;
      m   = (m + (big_type'(1) <<< (sh - 1))) >>> sh;
      return clamp(neg ? -m : m, w);
   endfunction

   function automatic big_type gain(input big_type n, input big_type d);
      big_type m, q;
      m = (n < 0) ? -n : n;
      q = (m <<< COV_FRAC) / d;
      return clamp((n < 0) ? -q : q, COV_W);
   endfunction

   function automatic estimate_type filter_step(input logic kind,
                                                input logic signed [SIG_W-1:0] meas,
                                                input logic signed [SIG_W-1:0] rate_in,
                                                input logic [DT_W-1:0] dt_in);
      estimate_type e;
      big_type dt, rate, pred, t, inner, p00, p01, p10, p11, innov, s, k0, k1;
      if (!kind) begin
         angle_st = meas;
         bias_st  = '0;
         p_aa     = RST_P00;
         p_ab     = '0;
         p_ba     = '0;
         p_bb     = RST_P11;
         e.rate   = '0;
      end else begin
         dt    = big_type'({1'b0, dt_in});
         rate  = clamp(big_type'(rate_in) - big_type'(bias_st), SIG_W);
         pred  = clamp(big_type'(angle_st) + scaled_product(dt, rate, SIG_FRAC, 63), SIG_W);
         t     = scaled_product(dt, big_type'(p_bb), SIG_FRAC, COV_W);
         inner = clamp(t - big_type'(p_ab) - big_type'(p_ba) + big_type'({1'b0, q_angle}),
                       COV_W);
         p00   = clamp(big_type'(p_aa) + scaled_product(dt, inner, SIG_FRAC, COV_W), COV_W);
         p01   = clamp(big_type'(p_ab) - t, COV_W);
         p10   = clamp(big_type'(p_ba) - t, COV_W);
         p11   = clamp(big_type'(p_bb) +
                       scaled_product(big_type'({1'b0, q_bias}), dt, SIG_FRAC, COV_W), COV_W);
         innov = big_type'(meas) - pred;
         s     = p00 + big_type'({1'b0, r_meas});
         if (s < 1) s = 1;
         k0    = gain(p00, s);
         k1    = gain(p10, s);
         angle_st = SIG_W'(clamp(pred + scaled_product(k0, innov, COV_FRAC, 63), SIG_W));
         bias_st  = SIG_W'(clamp(big_type'(bias_st) +
                                 scaled_product(k1, innov, COV_FRAC, 63), SIG_W));
         p_aa  = COV_W'(clamp(p00 - scaled_product(k0, p00, COV_FRAC, 63), COV_W));
         p_ab  = COV_W'(clamp(p01 - scaled_product(k0, p01, COV_FRAC, 63), COV_W));
         p_ba  = COV_W'(clamp(p10 - scaled_product(k1, p00, COV_FRAC, 63), COV_W));
         p_bb  = COV_W'(clamp(p11 - scaled_product(k1, p01, COV_FRAC, 63), COV_W));
         e.rate = rate[SIG_W-1:0];
      end
      e.angle = angle_st;
      e.bias  = bias_st;
      return e;
   endfunction

   task automatic compare_field(input string field, input logic signed [SIG_W-1:0] expv,
                                input logic signed [SIG_W-1:0] act);
      if (act !== expv) begin
         mismatches++;
         fail_count++;
         if (mismatches <= 10)
            $display("mismatch response %0d %s: expected %0d, got %0d",
                     checked, field, expv, act);
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      mismatches = 0;
   end

   always @(posedge clock) begin
      estimate_type e;
      if (reset) begin
         estimate_q.delete();
         pending  = 0;
         q_angle  = RST_QA;
         q_bias   = RST_QB;
         r_meas   = RST_R;
         angle_st = '0;
         bias_st  = '0;
         p_aa     = RST_P00;
         p_ab     = '0;
         p_ba     = '0;
         p_bb     = RST_P11;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_idx_type'(csr_chan.index))
               CSR_ANGLE_NOISE: q_angle = csr_chan.data;
               CSR_BIAS_NOISE:  q_bias  = csr_chan.data;
               CSR_MEAS_NOISE:  r_meas  = csr_chan.data;
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (estimate_q.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10) $display("response with no request outstanding");
            end else begin
               e = estimate_q.pop_front();
               compare_field("angle_estimate", e.angle, rsp_chan.angle_estimate);
               compare_field("bias_estimate", e.bias, rsp_chan.bias_estimate);
               compare_field("corrected_rate", e.rate, rsp_chan.corrected_rate);
            end
            checked++;
         end
         if (req_chan.valid && req_chan.ready)
            estimate_q.push_back(filter_step(req_chan.kind, req_chan.angle_measurement,
                                             req_chan.rate_measurement,
                                             req_chan.time_step));
         pending = estimate_q.size();
      end
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the angle/bias Kalman filter: directed restarts and updates at
// the field extremes, then random request streams under several noise
// settings and idle patterns, with one long response stall.
// ----------------------------------------------------------------------------
module tb;
   import abkf_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int BLOCK_ITEMS = 135;
   localparam logic [REG_W-1:0] REG_MAX = 45'd17592186044416;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle, recv_idle;
   logic hold_go = 1'b0;
   int   hold_left = 0;
   int   cycles = 0;
   int   sent = 0;
   int   fail_count, pending, checked;

   abkf_req_if req_chan ();
   abkf_rsp_if rsp_chan ();
   abkf_csr_if csr_chan ();

   angle_bias_kalman_filter_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   abkf_estimate_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_go) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      rsp_chan.ready <= !reset && hold_left == 0 && !hold_go &&
                        ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic send(input logic kind, input logic signed [SIG_W-1:0] ang,
                       input logic signed [SIG_W-1:0] rate, input logic [DT_W-1:0] dt);
      while ($urandom_range(0, 99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.kind              <= kind;
      req_chan.angle_measurement <= ang;
      req_chan.rate_measurement  <= rate;
      req_chan.time_step         <= dt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [REG_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_noise(input logic [REG_W-1:0] qa, input logic [REG_W-1:0] qb,
                            input logic [REG_W-1:0] r);
      drain();
      write_reg(CSR_ANGLE_NOISE, qa);
      write_reg(CSR_BIAS_NOISE, qb);
      write_reg(CSR_MEAS_NOISE, r);
   endtask

   function automatic logic signed [SIG_W-1:0] rand_signal();
      if ($urandom_range(0, 2) == 0) return $urandom;
      return $signed($urandom_range(0, 1 << 27)) - (1 << 26);
   endfunction

   task automatic random_items(input int n);
      logic [DT_W-1:0] dt;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         if (r == 0) dt = 25'd16777216;
         else if (r < 3) dt = DT_W'($urandom_range(0, 16777216));
         else dt = DT_W'($urandom_range(0, 1 << 20));
         send($urandom_range(0, 9) != 0, rand_signal(), rand_signal(), dt);
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind = 1'b0;
      req_chan.angle_measurement = '0;
      req_chan.rate_measurement = '0;
      req_chan.time_step = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_ANGLE_NOISE;
      csr_chan.data = '0;
      send_idle = 12;
      recv_idle = 87;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, restarts, zero and full time steps
      send(1'b1, 32'sd16777216, 32'sd1677721, 25'd167772);
      send(1'b1, 32'sd0, 32'sd0, 25'd0);
      send(1'b0, 32'sh7fffffff, 32'sd0, 25'd0);
      send(1'b1, 32'sh7fffffff, 32'sh7fffffff, 25'd16777216);
      send(1'b1, 32'sh7fffffff, 32'sh7fffffff, 25'd16777216);
      send(1'b0, 32'sh80000000, 32'sh7fffffff, 25'h1ffffff);
      send(1'b1, 32'sh80000000, 32'sh80000000, 25'd16777216);
      send(1'b1, 32'sh80000000, 32'sh80000000, 25'd1);
      send(1'b1, 32'sh7fffffff, 32'sh80000000, 25'd16777216);
      send(1'b0, 32'sd0, 32'sh80000000, 25'd16777216);
      send(1'b1, -32'sd8388608, 32'sd33554432, 25'd16777);
      send(1'b1, -32'sd8388608, -32'sd33554432, 25'd16777);
      send(1'b1, 32'sd5000000, 32'sd1000, 25'd8388608);
      send(1'b1, 32'sd5000000, 32'sd1000, 25'd0);
      send(1'b1, 32'sh7fffffff, 32'sh7fffffff, 25'd0);
      set_noise(REG_MAX, REG_MAX, REG_MAX);
      send(1'b1, 32'sh7fffffff, 32'sh80000000, 25'd16777216);
      send(1'b1, 32'sh80000000, 32'sh7fffffff, 25'd16777216);
      set_noise(45'd0, 45'd0, 45'd1);
      send(1'b1, 32'sh7fffffff, 32'sh7fffffff, 25'd16777216);
      send(1'b1, 32'sd0, 32'sd0, 25'd16777216);
      set_noise(RST_QA, RST_QB, RST_R);

      random_items(BLOCK_ITEMS / 2);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      random_items(BLOCK_ITEMS - BLOCK_ITEMS / 2);

      set_noise(REG_MAX, REG_MAX, REG_MAX);
      send_idle = 87;
      recv_idle = 12;
      random_items(BLOCK_ITEMS);

      set_noise(45'd0, 45'd0, 45'd1);
      send_idle = 0;
      recv_idle = 0;
      random_items(BLOCK_ITEMS);

      set_noise(REG_W'({$urandom_range(0, 4095), $urandom}),
                REG_W'({$urandom_range(0, 4095), $urandom}),
                REG_W'({$urandom_range(1, 4095), $urandom}));
      random_items(BLOCK_ITEMS);

      drain();
      repeat (200) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, %0d field mismatches", sent,
               checked, fail_count);
      $display("noise settings: reset values, all maximum, all minimum, random");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
